FILE: rtl/bsp_pkg.sv
// Shared constants, types and state codes for the bucket slot placement block.
package bsp_pkg;

  localparam int BINS     = 4096;
  localparam int SLOTS    = 64;
  localparam int BIN_W    = $clog2(BINS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CFG_W    = 13;
  localparam int CNT_W    = BIN_W + 1;
  localparam int NEXT_W   = CFG_W + 1;

  localparam logic [0:0] CFG_PRIMARY = 1'b0;
  localparam logic [0:0] CFG_TOTAL   = 1'b1;

  localparam logic [CFG_W-1:0] PRIMARY_RST = CFG_W'(2048);
  localparam logic [CFG_W-1:0] TOTAL_RST   = CFG_W'(4096);

  localparam logic STATUS_PLACED    = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } search_res_t;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_EVAL    = 7'b0000100,
    S_OVF     = 7'b0001000,
    S_UNDO_RD = 7'b0010000,
    S_UNDO_WR = 7'b0100000,
    S_FAIL    = 7'b1000000
  } state_t;

endpackage

FILE: rtl/bsp_free_search.sv
// Cyclic first-free slot search over one bin's occupancy map.
module bsp_free_search
  import bsp_pkg::*;
(
  input  logic [SLOTS-1:0]  occ,
  input  logic [SLOT_W-1:0] start,
  input  logic              skip,
  output search_res_t       res
);

  logic [2*SLOTS-1:0] dbl;
  logic [SLOTS-1:0]   rot;
  logic [SLOTS-1:0]   free;

  always_comb begin
    dbl  = {occ, occ};
    rot  = dbl[start +: SLOTS];
    free = ~rot;
    if (skip) begin
      free[0] = 1'b0;
    end
    res = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (free[k]) begin
        res.found = 1'b1;
        res.slot  = start + SLOT_W'(k);
      end
    end
  end

endmodule

FILE: rtl/bucket_slot_placement.sv
// Top level: slot placement for a bucketized hash store with overflow bins.
// A hit in the first bin is found in S_EVAL and registered to the output; each bin hop
// passes through S_OVF and back to S_EVAL and costs an overflow map read and an occupancy
// read. Input is taken only in S_IDLE, so a new item waits until the last one has its result.
// A failed request undoes each allocation through S_UNDO_RD and S_UNDO_WR. Reset: a clearing
// pass zeroes occupancy and overflow maps; no input is taken during it, configuration writes are.
module bucket_slot_placement
  import bsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BIN_W-1:0]  in_bin_index,
  input  logic [SLOT_W-1:0] in_slot_index,
  input  logic              in_is_new,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BIN_W-1:0]  out_write_bin,
  output logic [SLOT_W-1:0] out_write_slot,
  output logic              out_whole_bin,
  output logic              out_status
);

  state_t             state_r, state_nxt;
  logic [BIN_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0]   primary_r, total_r;
  logic [BIN_W-1:0]   used_r, used_nxt;
  logic [BIN_W-1:0]   used0_r, used0_nxt;
  logic [CNT_W-1:0]   npend_r, npend_nxt;
  logic [CNT_W-1:0]   hops_r, hops_nxt;
  logic [BIN_W-1:0]   bin_r, bin_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               fresh_r, fresh_nxt;
  logic               first_r, first_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0]   out_bin_r, out_bin_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_whole_r, out_whole_nxt;
  logic               out_status_r, out_status_nxt;
  logic               out_load;

  logic [SLOTS-1:0]   occ_mem [BINS];
  logic [SLOTS-1:0]   occ_q;
  logic               occ_re, occ_we;
  logic [BIN_W-1:0]   occ_raddr, occ_waddr;
  logic [SLOTS-1:0]   occ_wdata;

  logic [BIN_W:0]     ovf_mem [BINS];
  logic [BIN_W:0]     ovf_q;
  logic               ovf_re, ovf_we;
  logic [BIN_W-1:0]   ovf_raddr, ovf_waddr;
  logic [BIN_W:0]     ovf_wdata;

  logic [BIN_W-1:0]   pend_mem [BINS];
  logic [BIN_W-1:0]   pend_q;
  logic               pend_re, pend_we;
  logic [BIN_W-1:0]   pend_raddr, pend_waddr;
  logic [BIN_W-1:0]   pend_wdata;

  search_res_t        srch;
  logic               direct;
  logic               out_free;
  logic [SLOT_W-1:0]  sel_slot;
  logic [NEXT_W-1:0]  next_bin;
  logic [CFG_W-1:0]   lim;
  logic               exhaust;
  logic [CNT_W-1:0]   hops_inc;
  logic               hop_fail;

  bsp_free_search u_search (
    .occ   (occ_q),
    .start (slot_r),
    .skip  (first_r),
    .res   (srch)
  );

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_write_bin  = out_bin_r;
  assign out_write_slot = out_slot_r;
  assign out_whole_bin  = out_whole_r;
  assign out_status     = out_status_r;

  assign direct   = first_r && (!fresh_r || !occ_q[slot_r]);
  assign out_free = !out_valid_r || out_ready;
  assign sel_slot = direct ? slot_r : srch.slot;
  assign next_bin = {1'b0, primary_r} + NEXT_W'(used_r);
  assign lim      = (total_r < CFG_W'(BINS)) ? total_r : CFG_W'(BINS);
  assign exhaust  = ((next_bin + NEXT_W'(1)) >= NEXT_W'(lim)) || (npend_r >= CNT_W'(BINS));
  assign hops_inc = hops_r + CNT_W'(1);
  assign hop_fail = hops_inc > CNT_W'(BINS);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    used_nxt       = used_r;
    used0_nxt      = used0_r;
    npend_nxt      = npend_r;
    hops_nxt       = hops_r;
    bin_nxt        = bin_r;
    slot_nxt       = slot_r;
    fresh_nxt      = fresh_r;
    first_nxt      = first_r;
    out_load       = 1'b0;
    out_bin_nxt    = out_bin_r;
    out_slot_nxt   = out_slot_r;
    out_whole_nxt  = out_whole_r;
    out_status_nxt = out_status_r;
    occ_re         = 1'b0;
    occ_raddr      = bin_r;
    occ_we         = 1'b0;
    occ_waddr      = bin_r;
    occ_wdata      = occ_q | (SLOTS'(1) << sel_slot);
    ovf_re         = 1'b0;
    ovf_raddr      = bin_r;
    ovf_we         = 1'b0;
    ovf_waddr      = bin_r;
    ovf_wdata      = {1'b1, next_bin[BIN_W-1:0]};
    pend_re        = 1'b0;
    pend_raddr     = npend_r[BIN_W-1:0] - BIN_W'(1);
    pend_we        = 1'b0;
    pend_waddr     = npend_r[BIN_W-1:0];
    pend_wdata     = bin_r;

    case (state_r)
      S_CLEAR: begin
        occ_we       = 1'b1;
        occ_waddr    = clr_addr_r;
        occ_wdata    = '0;
        ovf_we       = 1'b1;
        ovf_waddr    = clr_addr_r;
        ovf_wdata    = '0;
        clr_addr_nxt = clr_addr_r + BIN_W'(1);
        if (clr_addr_r == BIN_W'(BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          bin_nxt   = in_bin_index;
          slot_nxt  = in_slot_index;
          fresh_nxt = in_is_new;
          first_nxt = 1'b1;
          hops_nxt  = '0;
          npend_nxt = '0;
          used0_nxt = used_r;
          occ_re    = 1'b1;
          occ_raddr = in_bin_index;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (direct || srch.found) begin
          if (out_free) begin
            occ_we         = 1'b1;
            out_load       = 1'b1;
            out_bin_nxt    = bin_r;
            out_slot_nxt   = sel_slot;
            out_whole_nxt  = (occ_q == '0);
            out_status_nxt = STATUS_PLACED;
            state_nxt      = S_IDLE;
          end
        end else begin
          hops_nxt  = hops_inc;
          first_nxt = 1'b0;
          if (hop_fail) begin
            used_nxt  = used0_r;
            state_nxt = (npend_r != '0) ? S_UNDO_RD : S_FAIL;
          end else begin
            ovf_re    = 1'b1;
            state_nxt = S_OVF;
          end
        end
      end
      S_OVF: begin
        if (ovf_q[BIN_W]) begin
          bin_nxt   = ovf_q[BIN_W-1:0];
          occ_re    = 1'b1;
          occ_raddr = ovf_q[BIN_W-1:0];
          state_nxt = S_EVAL;
        end else if (exhaust) begin
          used_nxt  = used0_r;
          state_nxt = (npend_r != '0) ? S_UNDO_RD : S_FAIL;
        end else begin
          ovf_we    = 1'b1;
          pend_we   = 1'b1;
          npend_nxt = npend_r + CNT_W'(1);
          used_nxt  = used_r + BIN_W'(1);
          bin_nxt   = next_bin[BIN_W-1:0];
          occ_re    = 1'b1;
          occ_raddr = next_bin[BIN_W-1:0];
          state_nxt = S_EVAL;
        end
      end
      S_UNDO_RD: begin
        pend_re   = 1'b1;
        npend_nxt = npend_r - CNT_W'(1);
        state_nxt = S_UNDO_WR;
      end
      S_UNDO_WR: begin
        ovf_we    = 1'b1;
        ovf_waddr = pend_q;
        ovf_wdata = '0;
        state_nxt = (npend_r == '0) ? S_FAIL : S_UNDO_RD;
      end
      S_FAIL: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_bin_nxt    = '0;
          out_slot_nxt   = '0;
          out_whole_nxt  = 1'b0;
          out_status_nxt = STATUS_EXHAUSTED;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      primary_r   <= PRIMARY_RST;
      total_r     <= TOTAL_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRIMARY: primary_r <= cfg_wdata;
          CFG_TOTAL:   total_r   <= cfg_wdata;
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    used0_r      <= used0_nxt;
    npend_r      <= npend_nxt;
    hops_r       <= hops_nxt;
    bin_r        <= bin_nxt;
    slot_r       <= slot_nxt;
    fresh_r      <= fresh_nxt;
    first_r      <= first_nxt;
    out_bin_r    <= out_bin_nxt;
    out_slot_r   <= out_slot_nxt;
    out_whole_r  <= out_whole_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (occ_re) begin
      occ_q <= occ_mem[occ_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf_we) begin
      ovf_mem[ovf_waddr] <= ovf_wdata;
    end
    if (ovf_re) begin
      ovf_q <= ovf_mem[ovf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    if (pend_re) begin
      pend_q <= pend_mem[pend_raddr];
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input taken during clearing pass");

  a_pending_tracks_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL || state_r == S_OVF) |-> (npend_r == CNT_W'(used_r - used0_r)))
    else $error("pending allocation count out of step with overflow counter");

  a_fail_restores_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FAIL) |-> (used_r == used0_r))
    else $error("exhausted request left overflow counter changed");

  a_undo_ends_in_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNDO_WR && npend_r == '0) |=> (state_r == S_FAIL))
    else $error("undo did not finish with an exhausted result");

endmodule

FILE: bench/bucket_slot_placement_tb.sv
// Self-checking bench for bucket slot placement: mirrors the store and checks every result.
module bucket_slot_placement_tb;
  import bsp_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [BIN_W-1:0]  bin;
    logic [SLOT_W-1:0] slot;
    logic              whole;
    logic              status;
  } placement_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_PRIMARY;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BIN_W-1:0]  in_bin_index = '0;
  logic [SLOT_W-1:0] in_slot_index = '0;
  logic              in_is_new = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BIN_W-1:0]  out_write_bin;
  logic [SLOT_W-1:0] out_write_slot;
  logic              out_whole_bin;
  logic              out_status;

  logic [SLOTS-1:0] occ_map [BINS];
  logic [BIN_W-1:0] chain_next [BINS];
  logic             chain_valid [BINS];
  int unsigned      chain_used;
  int unsigned      cfg_primary;
  int unsigned      cfg_total;

  placement_t  due_placements [$];
  placement_t  head;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;

  bucket_slot_placement dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_bin_index  (in_bin_index),
    .in_slot_index (in_slot_index),
    .in_is_new     (in_is_new),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_write_bin (out_write_bin),
    .out_write_slot(out_write_slot),
    .out_whole_bin (out_whole_bin),
    .out_status    (out_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 3);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check on the falling edge the transfer taken at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_placements.size() == 0) begin
        $error("result with none expected: bin %0d slot %0d", out_write_bin, out_write_slot);
        failures++;
      end else begin
        head = due_placements.pop_front();
        if (out_write_bin !== head.bin) begin
          $error("write_bin: expected %0d, actual %0d", head.bin, out_write_bin);
          failures++;
        end
        if (out_write_slot !== head.slot) begin
          $error("write_slot: expected %0d, actual %0d", head.slot, out_write_slot);
          failures++;
        end
        if (out_whole_bin !== head.whole) begin
          $error("whole_bin: expected %0d, actual %0d", head.whole, out_whole_bin);
          failures++;
        end
        if (out_status !== head.status) begin
          $error("status: expected %0d, actual %0d", head.status, out_status);
          failures++;
        end
      end
    end
  end

  function automatic placement_t place_key(input logic [BIN_W-1:0] bin_in,
                                           input logic [SLOT_W-1:0] slot_in,
                                           input logic fresh);
    placement_t  r;
    int unsigned b, s, start, hops, skip, nxt, lim, used0, k;
    int unsigned linked [$];
    logic        found, failed;
    r = '0;
    b = bin_in;
    s = slot_in;
    if (fresh && occ_map[b][s]) begin
      start = s;
      used0 = chain_used;
      hops = 0;
      skip = 1;
      found = 1'b0;
      failed = 1'b0;
      lim = (cfg_total < BINS) ? cfg_total : BINS;
      while (!found && !failed) begin
        for (k = skip; k < SLOTS; k++)
          if (!found && !occ_map[b][(start + k) % SLOTS]) begin
            found = 1'b1;
            s = (start + k) % SLOTS;
          end
        if (!found) begin
          skip = 0;
          hops++;
          if (hops > BINS) begin
            failed = 1'b1;
          end else if (chain_valid[b]) begin
            b = chain_next[b];
          end else begin
            nxt = cfg_primary + chain_used;
            if (nxt + 1 >= lim) begin
              failed = 1'b1;
            end else begin
              chain_next[b] = BIN_W'(nxt);
              chain_valid[b] = 1'b1;
              linked.push_back(b);
              chain_used++;
              b = nxt;
            end
          end
        end
      end
      if (failed) begin
        foreach (linked[i]) chain_valid[linked[i]] = 1'b0;
        chain_used = used0;
        r.status = STATUS_EXHAUSTED;
        return r;
      end
    end
    r.whole = (occ_map[b] == '0);
    occ_map[b][s] = 1'b1;
    r.bin = BIN_W'(b);
    r.slot = SLOT_W'(s);
    r.status = STATUS_PLACED;
    return r;
  endfunction

  task automatic send_key(input int unsigned b, input int unsigned s, input bit fresh);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_bin_index <= BIN_W'(b);
    in_slot_index <= SLOT_W'(s);
    in_is_new <= fresh;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    due_placements.push_back(place_key(BIN_W'(b), SLOT_W'(s), fresh));
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (due_placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PRIMARY) cfg_primary = value;
    else cfg_total = value;
  endtask

  task automatic set_bins(input int unsigned primary, input int unsigned total);
    drain_results;
    write_reg(CFG_PRIMARY, CFG_W'(primary));
    write_reg(CFG_TOTAL, CFG_W'(total));
  endtask

  task automatic fill_bin(input int unsigned b, input int unsigned count);
    repeat (count) send_key(b, $urandom_range(0, SLOTS - 1), 1'b1);
  endtask

  task automatic test_direct_placement;
    send_key(0, 0, 1'b0);
    send_key(0, 0, 1'b1);
    send_key(BINS - 1, SLOTS - 1, 1'b1);
    send_key(BINS - 1, SLOTS - 1, 1'b1);
    send_key(BINS - 1, SLOTS - 1, 1'b0);
    send_key(0, 1, 1'b0);
    send_key(12'hAAA, 6'h2A, 1'b1);
    send_key(12'h555, 6'h15, 1'b1);
    send_key(12'h555, 6'h15, 1'b0);
    send_key(0, SLOTS - 1, 1'b1);
    send_key(0, SLOTS - 1, 1'b1);
  endtask

  task automatic test_overflow_allocation;
    set_bins(16, 19);
    fill_bin(3, SLOTS);
    send_key(3, 7, 1'b1);
    fill_bin(3, SLOTS - 1);
    fill_bin(17, SLOTS);
    // two bins needed, only one left: undo the allocation
    send_key(3, 6'h2A, 1'b1);
    set_bins(16, 20);
    send_key(3, 6'h15, 1'b1);
    send_key(17, 9, 1'b0);
  endtask

  task automatic test_chain_limits;
    fill_bin(18, SLOTS - 1);
    // next overflow bin points back at the full bin itself
    set_bins(18 - chain_used, BINS);
    send_key(18, $urandom_range(0, SLOTS - 1), 1'b1);
    send_key(3, $urandom_range(0, SLOTS - 1), 1'b1);
    set_bins(1, 2);
    send_key(18, $urandom_range(0, SLOTS - 1), 1'b1);
    set_bins(BINS, BINS);
    send_key(3, $urandom_range(0, SLOTS - 1), 1'b1);
    set_bins(1, BINS);
    send_key(18, $urandom_range(0, SLOTS - 1), 1'b1);
  endtask

  task automatic test_random_traffic;
    int unsigned base, span, pick, b;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      base = 256 + p * 448;
      span = $urandom_range(1, 3);
      set_bins((base + 8 > chain_used) ? base + 8 - chain_used : 1,
               base + 8 + $urandom_range(2, 8));
      gaps_on = (p % 3 != 2) && (p != RANDOM_PHASES - 1);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) b = base + $urandom_range(0, span - 1);
        else if (pick < 8) b = base + 8 + $urandom_range(0, 7);
        else b = $urandom_range(0, BINS - 1);
        send_key(b, $urandom_range(0, SLOTS - 1), $urandom_range(0, 7) != 0);
      end
    end
  endtask

  initial begin
    foreach (occ_map[i]) begin
      occ_map[i] = '0;
      chain_next[i] = '0;
      chain_valid[i] = 1'b0;
    end
    chain_used = 0;
    cfg_primary = PRIMARY_RST;
    cfg_total = TOTAL_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_direct_placement;
    test_overflow_allocation;
    test_chain_limits;
    test_random_traffic;
    drain_results;
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bsp_pkg.sv
rtl/bsp_free_search.sv
rtl/bucket_slot_placement.sv
bench/bucket_slot_placement_tb.sv
